// ----- rtl/joystick_motor_power_conditioner_unit_defines.svh -----
// assertion macros for the joystick motor power conditioner
// used by the checker; expects clock and reset in the calling scope
`ifndef JOYSTICK_MOTOR_POWER_CONDITIONER_UNIT_DEFINES_SVH
`define JOYSTICK_MOTOR_POWER_CONDITIONER_UNIT_DEFINES_SVH

// condition in the same cycle
`define JMPC_CHK_SAME(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("jmpc check failed in same cycle");

// condition in the following cycle
`define JMPC_CHK_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("jmpc check failed in next cycle");

// payload of a stalled transfer holds
`define JMPC_CHK_HOLD(lbl, vld, rdy, sig) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (vld && !rdy) |=> (vld && $stable(sig))) \
      else $error("jmpc stalled payload changed");

`endif

// ----- rtl/jmpc_pkg.sv -----
// shared constants, register indexes and helpers for the joystick power conditioner
// no dependencies
`default_nettype none

package jmpc_pkg;

   localparam int CURVE_DEGREE_DEF = 1;
   localparam int DVD_W = 32;

   // input transfer layout, lowest bit first
   localparam int STICK_W  = 8;
   localparam int POS_W    = 20;
   localparam int TIME_W   = 32;
   localparam int STICK_LO = 0;
   localparam int POS_LO   = STICK_LO + STICK_W;
   localparam int TIME_LO  = POS_LO + POS_W;
   localparam int APPLY_B  = TIME_LO + TIME_W;
   localparam int OVR_B    = APPLY_B + 1;
   localparam int REQ_W    = 64;
   localparam int PWR_W    = 8;
   localparam int RSP_W    = 2 * PWR_W;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 20;
   localparam logic [CSR_AW-1:0] REG_DEADBAND     = 3'd0;
   localparam logic [CSR_AW-1:0] REG_RAMP_PERIOD  = 3'd1;
   localparam logic [CSR_AW-1:0] REG_MAX_POWER    = 3'd2;
   localparam logic [CSR_AW-1:0] REG_LOWER_LIMIT  = 3'd3;
   localparam logic [CSR_AW-1:0] REG_UPPER_LIMIT  = 3'd4;
   localparam logic [CSR_AW-1:0] REG_PUSH_MAX     = 3'd5;
   localparam logic [CSR_AW-1:0] REG_DEFAULT_PWR  = 3'd6;
   localparam logic [CSR_AW-1:0] REG_LIMIT_ENABLE = 3'd7;

   localparam logic [6:0] DEADBAND_RST  = 7'd10;
   localparam logic [6:0] MAX_POWER_RST = 7'd127;
   localparam logic [6:0] PUSH_MAX_RST  = 7'd20;
   localparam logic [6:0] MAG_MAX       = 7'd127;

   function automatic int den_pow(input int deg);
      int p;
      p = 1;
      for (int i = 0; i < deg; i++) begin
         p = p * 127;
      end
      return p;
   endfunction

   // magnitude of an 8 bit signed value; -128 gives 128
   function automatic logic [7:0] abs8(input logic [7:0] v);
      return v[7] ? 8'(-v) : v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/jmpc_div.sv -----
// radix-2 restoring divider, two quotient bits per cycle
// depends on jmpc_pkg
`default_nettype none

module jmpc_div #(
   parameter int DVD_W = jmpc_pkg::DVD_W,
   parameter int DSR_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DSR_W-1:0] remainder
);
   import jmpc_pkg::*;

   localparam int STEPS = DVD_W / 2;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;

   logic [DSR_W:0]   t1, t2;
   logic             ge1, ge2;
   logic [DSR_W-1:0] r1, r2;

   always_comb begin
      t1  = {rem_ff, quo_ff[DVD_W-1]};
      ge1 = t1 >= {1'b0, dsr_ff};
      r1  = ge1 ? DSR_W'(t1 - {1'b0, dsr_ff}) : t1[DSR_W-1:0];
      t2  = {r1, quo_ff[DVD_W-2]};
      ge2 = t2 >= {1'b0, dsr_ff};
      r2  = ge2 ? DSR_W'(t2 - {1'b0, dsr_ff}) : t2[DSR_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = r2;
         quo_in = {quo_ff[DVD_W-3:0], ge1, ge2};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/joystick_motor_power_conditioner_unit.sv -----
// joystick motor power conditioner: curve shaping, deadband, ramp and position limits
// depends on jmpc_pkg and jmpc_div
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tdata: stick, position, now_ms, apply, ovr
//   rsp     | out       | rsp_tvalid/tready    | tdata: requested_power, applied_power
//   csr     | in        | csr_we               | csr_addr, csr_wdata
//
// the result follows the input transfer through one multiply per degree, one reciprocal
// scaling step, then ramp, limit and output; a ramp divide adds a divider run and its
// read-out. req_tready is high only while idle and comes back with the result, so the
// block works on one transfer at a time.
// a waiting result keeps the next item's result in the hold step until the output register is free.
// reset clears sequencer, stored power, time base and registers at once; no sweep.
`default_nettype none

module joystick_motor_power_conditioner_unit #(
   parameter int CURVE_DEGREE = jmpc_pkg::CURVE_DEGREE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // stick[7:0], position[27:8], now_ms[59:28], apply[60], override_limits[61], zero
   input  logic [jmpc_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // requested_power[7:0], applied_power[15:8]
   output logic [jmpc_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [jmpc_pkg::CSR_AW-1:0] csr_addr,
   input  logic [jmpc_pkg::CSR_DW-1:0] csr_wdata
);
   import jmpc_pkg::*;

   localparam int DEG   = (CURVE_DEGREE < 1) ? 1 : ((CURVE_DEGREE > 3) ? 3 : CURVE_DEGREE);
   localparam int NUM_W = 7 + 7 * DEG;
   localparam int DSR_W = 7;
   // floor(x / 127^DEG) as (x * RECIP) >> RSH, exact for every x below 2^NUM_W
   localparam int DEN_I   = den_pow(DEG);
   localparam int DEN_LOG = $clog2(DEN_I);
   localparam int RSH     = NUM_W + DEN_LOG;
   localparam int MUL_W   = 2 * NUM_W + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << RSH) + 64'(DEN_I) - 64'd1) / 64'(DEN_I);
   localparam logic [NUM_W:0] RECIP = (NUM_W + 1)'(RECIP_L);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_SDIV  = 3'd2;
   localparam logic [2:0] S_RAMP  = 3'd3;
   localparam logic [2:0] S_RDIV  = 3'd4;
   localparam logic [2:0] S_LIMIT = 3'd5;
   localparam logic [2:0] S_HOLD  = 3'd6;

   // configuration
   logic [6:0]              deadband_ff, period_ff, max_power_ff, push_ff;
   logic signed [POS_W-1:0] lower_ff, upper_ff;
   logic signed [7:0]       def_pwr_ff;
   logic [1:0]              lim_en_ff;

   // sequencer and item
   logic [2:0]              state_ff, state_in;
   logic [1:0]              mcnt_ff, mcnt_in;
   logic [NUM_W-1:0]        acc_ff, acc_in;
   logic signed [7:0]       stick_ff, stick_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic                    apply_ff, apply_in;
   logic                    ovr_ff, ovr_in;
   logic signed [7:0]       power_ff, power_in;
   logic signed [7:0]       applied_ff, applied_in;

   // stored state
   logic signed [7:0]       last_pwr_ff, last_pwr_in;
   logic [TIME_W-1:0]       last_upd_ff, last_upd_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   // ramp divider
   logic                    div_start, div_done;
   logic [DVD_W-1:0]        div_dvd, div_quo;
   logic [DSR_W-1:0]        div_dsr, div_rem;

   logic [7:0]              ax;
   logic [NUM_W:0]          mul_b;
   logic [MUL_W-1:0]        prod;
   logic [7:0]              quo8;
   logic [6:0]              mag_sat, mag_db;
   logic [TIME_W-1:0]       elapsed;
   logic signed [8:0]       dif, pw9, ap9, push9, npush9;
   logic [8:0]              adif;
   logic                    lower_hit, upper_hit;
   logic signed [7:0]       neg_def, applied1;

   jmpc_div #(
      .DVD_W(DVD_W),
      .DSR_W(DSR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   always_comb begin
      ax      = abs8(stick_ff);
      // one multiplier: stick magnitude while shaping, reciprocal while scaling
      mul_b   = (state_ff == S_SDIV) ? RECIP : (NUM_W + 1)'(ax);
      prod    = MUL_W'(acc_ff) * MUL_W'(mul_b);
      quo8    = prod[RSH +: 8];
      mag_sat = quo8[7] ? MAG_MAX : quo8[6:0];
      mag_db  = (mag_sat < deadband_ff) ? 7'd0 : mag_sat;
      elapsed = now_ff - last_upd_ff;
      dif     = {last_pwr_ff[7], last_pwr_ff} - {power_ff[7], power_ff};
      adif    = dif[8] ? 9'(-dif) : 9'(dif);
      // limit check: lower first, upper sees what lower left
      pw9       = {power_ff[7], power_ff};
      push9     = {2'b00, push_ff};
      npush9    = -push9;
      neg_def   = (def_pwr_ff == -8'sd128) ? 8'sd127 : -def_pwr_ff;
      lower_hit = lim_en_ff[0] && (pos_ff <= lower_ff) && (pw9 < npush9);
      applied1  = (!ovr_ff && lower_hit) ? neg_def : power_ff;
      ap9       = {applied1[7], applied1};
      upper_hit = lim_en_ff[1] && (pos_ff >= upper_ff) && (ap9 > push9);
   end

   always_comb begin
      state_in     = state_ff;
      mcnt_in      = mcnt_ff;
      acc_in       = acc_ff;
      stick_in     = stick_ff;
      pos_in       = pos_ff;
      now_in       = now_ff;
      apply_in     = apply_ff;
      ovr_in       = ovr_ff;
      power_in     = power_ff;
      applied_in   = applied_ff;
      last_pwr_in  = last_pwr_ff;
      last_upd_in  = last_upd_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_start    = 1'b0;
      div_dvd      = elapsed;
      div_dsr      = DSR_W'(period_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               stick_in = req_tdata[STICK_LO +: STICK_W];
               pos_in   = req_tdata[POS_LO +: POS_W];
               now_in   = req_tdata[TIME_LO +: TIME_W];
               apply_in = req_tdata[APPLY_B];
               ovr_in   = req_tdata[OVR_B];
               acc_in   = NUM_W'(max_power_ff);
               mcnt_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acc_in  = prod[NUM_W-1:0];
            mcnt_in = 2'(mcnt_ff + 1'b1);
            if (mcnt_ff == 2'(DEG - 1)) begin
               state_in = S_SDIV;
            end
         end
         S_SDIV: begin
            power_in = stick_ff[7] ? -$signed({1'b0, mag_db}) : $signed({1'b0, mag_db});
            state_in = S_RAMP;
         end
         S_RAMP: begin
            state_in = S_LIMIT;
            if (period_ff != 7'd0) begin
               if (elapsed < TIME_W'(period_ff)) begin
                  power_in = last_pwr_ff;
               end else begin
                  last_upd_in = now_ff;
                  if (abs8(power_ff) > abs8(last_pwr_ff)) begin
                     div_start = 1'b1;
                     state_in  = S_RDIV;
                  end
               end
            end
         end
         S_RDIV: begin
            if (div_done) begin
               // move k units toward the target, keeping the leftover of the period
               if (DVD_W'(adif) > div_quo) begin
                  last_upd_in = now_ff - TIME_W'(div_rem);
                  power_in = (power_ff > last_pwr_ff) ? last_pwr_ff + $signed(div_quo[7:0])
                                                      : last_pwr_ff - $signed(div_quo[7:0]);
               end
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            applied_in = (!ovr_ff && upper_hit) ? def_pwr_ff : applied1;
            if (apply_ff) begin
               last_pwr_in = applied_in;
            end
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {applied_ff, power_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_pwr_ff  <= '0;
         last_upd_ff  <= '0;
         deadband_ff  <= DEADBAND_RST;
         period_ff    <= '0;
         max_power_ff <= MAX_POWER_RST;
         lower_ff     <= '0;
         upper_ff     <= '0;
         push_ff      <= PUSH_MAX_RST;
         def_pwr_ff   <= '0;
         lim_en_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_pwr_ff  <= last_pwr_in;
         last_upd_ff  <= last_upd_in;
         if (csr_we) begin
            case (csr_addr)
               REG_DEADBAND:     deadband_ff  <= csr_wdata[6:0];
               REG_RAMP_PERIOD:  period_ff    <= csr_wdata[6:0];
               REG_MAX_POWER:    max_power_ff <= csr_wdata[6:0];
               REG_LOWER_LIMIT:  lower_ff     <= csr_wdata[POS_W-1:0];
               REG_UPPER_LIMIT:  upper_ff     <= csr_wdata[POS_W-1:0];
               REG_PUSH_MAX:     push_ff      <= csr_wdata[6:0];
               REG_DEFAULT_PWR:  def_pwr_ff   <= csr_wdata[7:0];
               REG_LIMIT_ENABLE: lim_en_ff    <= csr_wdata[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mcnt_ff     <= mcnt_in;
      acc_ff      <= acc_in;
      stick_ff    <= stick_in;
      pos_ff      <= pos_in;
      now_ff      <= now_in;
      apply_ff    <= apply_in;
      ovr_ff      <= ovr_in;
      power_ff    <= power_in;
      applied_ff  <= applied_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/jmpc_chk.sv -----
// port-level checker for the joystick motor power conditioner, bound to the top level
// depends on jmpc_pkg and the defines header
`default_nettype none
`include "joystick_motor_power_conditioner_unit_defines.svh"

module jmpc_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [jmpc_pkg::RSP_W-1:0] rsp_tdata
);
   import jmpc_pkg::*;

   // a waiting result keeps its payload
   `JMPC_CHK_HOLD(a_rsp_hold, rsp_tvalid, rsp_tready, rsp_tdata)
   // one item at a time: busy right after a transfer
   `JMPC_CHK_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)
   // an idle block with nothing offered stays ready
   `JMPC_CHK_NEXT(a_idle_stays, req_tready && !req_tvalid, req_tready)
   // a fresh result appears as the sequencer returns to idle
   `JMPC_CHK_SAME(a_result_idle, $rose(rsp_tvalid), req_tready)

endmodule

bind joystick_motor_power_conditioner_unit jmpc_chk u_jmpc_chk (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking bench for joystick_motor_power_conditioner_unit: shaping, deadband,
// ramp and position limits checked against a predictor held in a scoreboard class
// depends on jmpc_pkg and the unit's rtl
`default_nettype none

module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int REPORT_CAP     = 100;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 127;

   // receiver stall modes
   localparam int RX_OPEN   = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_HOLD   = 2;
   localparam int RX_SPARSE = 3;

   typedef struct packed {
      logic [7:0] req_pwr;
      logic [7:0] appl_pwr;
   } power_pair_type;

   typedef struct {
      int deadband;
      int ramp;
      int max_pwr;
      int lower;
      int upper;
      int push;
      int dflt;
      int en;
   } settings_type;

   class power_scoreboard_type;
      int unsigned deadband, ramp_ms, max_pwr, push_max, lim_en;
      int lower_pos, upper_pos, dflt_pwr;
      int last_pwr;
      logic [31:0] last_ms;
      int curve_deg;
      int errors;
      power_pair_type expected_q[$];

      function new(int deg);
         curve_deg = deg;
         deadband  = jmpc_pkg::DEADBAND_RST;
         ramp_ms   = 0;
         max_pwr   = jmpc_pkg::MAX_POWER_RST;
         push_max  = jmpc_pkg::PUSH_MAX_RST;
         lim_en    = 0;
         lower_pos = 0;
         upper_pos = 0;
         dflt_pwr  = 0;
         last_pwr  = 0;
         last_ms   = '0;
         errors    = 0;
      endfunction

      function int abs_i(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void set_reg(logic [jmpc_pkg::CSR_AW-1:0] idx,
                            logic [jmpc_pkg::CSR_DW-1:0] val);
         case (idx)
            jmpc_pkg::REG_DEADBAND:     deadband  = val[6:0];
            jmpc_pkg::REG_RAMP_PERIOD:  ramp_ms   = val[6:0];
            jmpc_pkg::REG_MAX_POWER:    max_pwr   = val[6:0];
            jmpc_pkg::REG_LOWER_LIMIT:  lower_pos = $signed(val);
            jmpc_pkg::REG_UPPER_LIMIT:  upper_pos = $signed(val);
            jmpc_pkg::REG_PUSH_MAX:     push_max  = val[6:0];
            jmpc_pkg::REG_DEFAULT_PWR:  dflt_pwr  = $signed(val[7:0]);
            jmpc_pkg::REG_LIMIT_ENABLE: lim_en    = val[1:0];
            default: ;
         endcase
      endfunction

      // works out the power pair for one accepted update and advances the stored state
      function void note_update(logic [7:0] stick, logic [19:0] pos, logic [31:0] now,
                                logic apply, logic ovr);
         int s, p, power, cur, applied, deg;
         longint unsigned num, den, mag;
         int unsigned ax, k;
         logic [31:0] elapsed;
         power_pair_type e;
         s = $signed(stick);
         p = $signed(pos);
         ax = abs_i(s);
         deg = curve_deg;
         if (deg < 1) deg = 1;
         if (deg > 3) deg = 3;
         num = max_pwr;
         den = 1;
         for (int i = 0; i < deg; i++) begin
            num = num * ax;
            den = den * 127;
         end
         mag = num / den;
         if (mag > 127) mag = 127;
         power = (s < 0) ? -int'(mag) : int'(mag);
         if (abs_i(power) < deadband) power = 0;

         if (ramp_ms != 0) begin
            elapsed = now - last_ms;
            cur = last_pwr;
            if (elapsed >= ramp_ms) begin
               last_ms = now;
               if (abs_i(power) > abs_i(cur)) begin
                  k = elapsed / ramp_ms;
                  if (abs_i(cur - power) > k) begin
                     // time base keeps the unused part of the period
                     last_ms = now - (elapsed % ramp_ms);
                     power = (power > cur) ? cur + int'(k) : cur - int'(k);
                  end
               end
            end else begin
               power = cur;
            end
         end

         applied = power;
         if (!ovr) begin
            if (lim_en[0] && p <= lower_pos && applied < -int'(push_max)) begin
               applied = -dflt_pwr;
               if (applied > 127) applied = 127;
            end
            if (lim_en[1] && p >= upper_pos && applied > int'(push_max))
               applied = dflt_pwr;
         end
         if (apply) last_pwr = applied;

         e.req_pwr  = power[7:0];
         e.appl_pwr = applied[7:0];
         expected_q.push_back(e);
      endfunction

      function void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
         if (errors < REPORT_CAP)
            $display("%0t: %s expected %0d actual %0d", $time, what,
                     $signed(exp_v), $signed(act_v));
         else if (errors == REPORT_CAP)
            $display("%0t: further mismatches not shown", $time);
         errors++;
      endfunction

      function void check_result(logic [jmpc_pkg::RSP_W-1:0] data);
         power_pair_type e;
         if (expected_q.size() == 0) begin
            if (errors < REPORT_CAP)
               $display("%0t: result %h with none expected, actual %h", $time, data, data);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (data[7:0] !== e.req_pwr) report("requested_power", e.req_pwr, data[7:0]);
            if (data[15:8] !== e.appl_pwr) report("applied_power", e.appl_pwr, data[15:8]);
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // stick[7:0], position[27:8], now_ms[59:28], apply[60], override_limits[61], zero
   logic [jmpc_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // requested_power[7:0], applied_power[15:8]
   logic [jmpc_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [jmpc_pkg::CSR_AW-1:0] csr_addr = '0;
   logic [jmpc_pkg::CSR_DW-1:0] csr_wdata = '0;

   power_scoreboard_type sb;
   int burst_left = 0;
   bit no_idle = 1'b0;
   int idle_cycles = 0;
   int rx_mode = RX_OPEN;
   int rx_win = 0;
   int rx_stall = 0;

   joystick_motor_power_conditioner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: a new stall pattern for each window, with a random mode and stall length
   always @(posedge clock) begin
      if (rx_win == 0) begin
         rx_mode  = $urandom_range(RX_OPEN, RX_SPARSE);
         rx_stall = $urandom_range(1, 24);
         rx_win   = 32;
      end
      rx_win--;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= $urandom_range(0, 1);
         RX_HOLD:   rsp_tready <= ((31 - rx_win) >= rx_stall);
         default:   rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_update(req_tdata[7:0], req_tdata[27:8], req_tdata[59:28],
                           req_tdata[60], req_tdata[61]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   task automatic send_update(int stick, int pos, logic [31:0] now, bit apply, bit ovr);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = no_idle ? 0 : $urandom_range(0, 12);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, ovr, apply, now, 20'(pos), 8'(stick)};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [jmpc_pkg::CSR_AW-1:0] addr, int val);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= 20'(val);
      @(posedge clock);
      sb.set_reg(addr, 20'(val));
   endtask

   task automatic apply_settings(settings_type s);
      write_reg(jmpc_pkg::REG_DEADBAND, s.deadband);
      write_reg(jmpc_pkg::REG_RAMP_PERIOD, s.ramp);
      write_reg(jmpc_pkg::REG_MAX_POWER, s.max_pwr);
      write_reg(jmpc_pkg::REG_LOWER_LIMIT, s.lower);
      write_reg(jmpc_pkg::REG_UPPER_LIMIT, s.upper);
      write_reg(jmpc_pkg::REG_PUSH_MAX, s.push);
      write_reg(jmpc_pkg::REG_DEFAULT_PWR, s.dflt);
      write_reg(jmpc_pkg::REG_LIMIT_ENABLE, s.en);
      csr_we <= 1'b0;
   endtask

   // low or high end now and then, otherwise anywhere in the range
   function automatic int pick(int lo, int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return lo;
      if (r < 4) return hi;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   initial begin
      settings_type s;
      logic [31:0] now_t;
      int tgt, pos, r;
      sb = new(jmpc_pkg::CURVE_DEGREE_DEF);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no ramp, limits off
      send_update(-128, 0, 32'd0, 1, 0);
      send_update(-127, -524288, 32'd1, 1, 0);
      send_update(127, 524287, 32'd2, 0, 0);
      send_update(0, 0, 32'hFFFF_FFFF, 1, 1);
      send_update(9, 5, 32'd3, 1, 0);
      send_update(10, 5, 32'd4, 1, 0);
      send_update(-10, 5, 32'd5, 1, 0);
      send_update(-9, 5, 32'd6, 1, 0);
      send_update(1, 5, 32'd7, 1, 0);
      send_update(64, 5, 32'd8, 1, 1);
      drain();

      // ramp on, both limits on, default power at its negative extreme
      s = '{deadband: 0, ramp: 5, max_pwr: 127, lower: -100, upper: 100,
            push: 20, dflt: -128, en: 3};
      apply_settings(s);
      send_update(127, 0, 32'hFFFF_FFFE, 1, 0);
      send_update(-127, -200, 32'd3, 1, 0);     // time wraps, lower limit saturates
      send_update(127, 300, 32'd4, 0, 0);       // inside the period
      send_update(127, 100, 32'd9, 1, 1);       // limit overridden
      send_update(0, 0, 32'd20, 1, 0);
      send_update(127, 0, 32'd31, 1, 0);        // ramp limited, remainder kept
      send_update(127, 0, 32'd36, 1, 0);
      send_update(-127, -100, 32'd50, 1, 0);
      send_update(-20, -100, 32'd60, 1, 0);
      send_update(21, 100, 32'd70, 1, 0);
      send_update(-128, -524288, 32'd100, 1, 0);
      drain();

      now_t = 32'd200;
      tgt = 0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph == 0) begin
            s = '{deadband: 0, ramp: 0, max_pwr: 0, lower: -524288, upper: -524288,
                  push: 0, dflt: -128, en: 0};
         end else if (ph == 1) begin
            s = '{deadband: 127, ramp: 100, max_pwr: 127, lower: 524287, upper: 524287,
                  push: 127, dflt: 127, en: 3};
         end else begin
            s.deadband = ($urandom_range(0, 2) == 0) ? pick(0, 127) : $urandom_range(0, 20);
            s.ramp     = ($urandom_range(0, 1) == 0) ? pick(0, 100) : $urandom_range(1, 8);
            s.max_pwr  = ($urandom_range(0, 2) == 0) ? pick(0, 127) : $urandom_range(90, 127);
            s.lower    = pick(-524288, 524287);
            s.upper    = pick(-524288, 524287);
            s.push     = pick(0, 127);
            s.dflt     = pick(-128, 127);
            s.en       = $urandom_range(0, 3);
         end
         apply_settings(s);
         no_idle = ($urandom_range(0, 3) == 0);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // the stick mostly holds a target so the ramp gets to walk toward it
            if ($urandom_range(0, 9) >= 6) begin
               if ($urandom_range(0, 3) == 0) begin
                  case ($urandom_range(0, 3))
                     0: tgt = -128;
                     1: tgt = -127;
                     2: tgt = 127;
                     default: tgt = 0;
                  endcase
               end else begin
                  tgt = int'($urandom_range(0, 255)) - 128;
               end
            end
            r = $urandom_range(0, 2);
            if (r == 0)
               pos = s.lower + int'($urandom_range(0, 8)) - 4;
            else if (r == 1)
               pos = s.upper + int'($urandom_range(0, 8)) - 4;
            else
               pos = int'($urandom_range(0, 20'hFFFFF)) - 524288;
            if (pos > 524287) pos = 524287;
            if (pos < -524288) pos = -524288;
            r = $urandom_range(0, 19);
            if (r < 16)
               now_t = now_t + $urandom_range(0, 3 * s.ramp + 10);
            else if (r < 18)
               now_t = $urandom();
            else
               now_t = 32'hFFFF_FFFF - $urandom_range(0, 5);
            send_update(tgt, pos, now_t, $urandom_range(0, 19) < 17,
                        $urandom_range(0, 19) < 3);
         end
         drain();
      end

      if (sb.errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/jmpc_pkg.sv
rtl/jmpc_div.sv
rtl/joystick_motor_power_conditioner_unit.sv
rtl/jmpc_chk.sv
tb/sv/tb_top.sv
